// ===== design/owdm_pkg.sv =====
// Package for the omni wheel drive mixer: word types, register codes and fixed constants.
`default_nettype none

package owdm_pkg;

    // Register indexes on the configuration port.
    localparam logic [2:0] CFG_ARM_LENGTH    = 3'd0;
    localparam logic [2:0] CFG_INV_RADIUS    = 3'd1;
    localparam logic [2:0] CFG_SPD_OFFSET    = 3'd2;
    localparam logic [2:0] CFG_PWM_PER_SPEED = 3'd3;
    localparam logic [2:0] CFG_PWM_FULL      = 3'd4;

    localparam logic [15:0] RST_ARM_LENGTH    = 16'd23593;
    localparam logic [15:0] RST_INV_RADIUS    = 16'd2560;
    localparam logic [15:0] RST_SPD_OFFSET    = 16'd256;
    localparam logic [23:0] RST_PWM_PER_SPEED = 24'd536981;
    localparam logic [15:0] RST_PWM_FULL      = 16'd65025;

    // sin(60 degrees) in Q0.16, kept positive in a signed 17 bit form.
    localparam logic signed [16:0] SIN60_Q16 = 17'sd56755;

    // Body term (Q.24) and wheel speed (Q.32) widths.
    localparam int TERM_W = 34;
    localparam int SPD_W  = 50;

    typedef struct packed {
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [15:0] yaw_rate;
    } t_in;

    typedef struct packed {
        logic [15:0] duty_one;
        logic [15:0] duty_two;
        logic [15:0] duty_three;
        logic        dir_one;
        logic        dir_two;
        logic        dir_three;
    } t_out;

    // Scaling registers shared by all three wheel lanes.
    typedef struct packed {
        logic [15:0] inv_radius;
        logic [15:0] spd_offset;
        logic [23:0] pwm_per_speed;
        logic [15:0] pwm_full;
    } t_lane_cfg;

    // Result of one wheel lane: duty and whether the speed was positive.
    typedef struct packed {
        logic [15:0] duty;
        logic        pos;
    } t_wheel;

endpackage

`default_nettype wire

// ===== design/owdm_wheel.sv =====
// One wheel lane: speed scaling, magnitude, duty multiply and saturation over four stages.
`default_nettype none

module owdm_wheel (
    input  wire                              i_clk,
    input  wire                              i_en,
    input  wire logic signed [owdm_pkg::TERM_W-1:0] i_term,
    input  wire owdm_pkg::t_lane_cfg         i_cfg,
    output owdm_pkg::t_wheel                 o_res
);
    import owdm_pkg::*;

    logic signed [SPD_W:0]   n_u_full;
    logic signed [SPD_W-1:0] r_u;
    logic signed [SPD_W-1:0] n_neg;
    logic [SPD_W-2:0]        n_mag;
    logic [SPD_W-1:0]        n_s;
    logic [SPD_W-1:0]        r_s;
    logic                    r_zero4;
    logic                    r_pos4;
    logic [41:0]             r_hi;
    logic [55:0]             r_lo;
    logic                    r_zero5;
    logic                    r_pos5;
    logic [73:0]             n_wide;
    logic [33:0]             n_d;
    logic [15:0]             n_duty;
    logic [15:0]             r_duty;
    logic                    r_pos6;

    always_comb begin
        n_u_full = i_term * $signed({1'b0, i_cfg.inv_radius});
        n_neg    = -r_u;
        n_mag    = r_u[SPD_W-1] ? n_neg[SPD_W-2:0] : r_u[SPD_W-2:0];
        n_s      = {1'b0, n_mag} + {10'b0, i_cfg.spd_offset, 24'b0};
        // Product s * pwm_per_speed rebuilt from its two halves, then Q.40 dropped.
        n_wide   = {r_hi, 32'b0} + {18'b0, r_lo};
        n_d      = n_wide[73:40];
        if (r_zero5) begin
            n_duty = 16'd0;
        end else if (n_d > {18'b0, i_cfg.pwm_full}) begin
            n_duty = i_cfg.pwm_full;
        end else begin
            n_duty = n_d[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u     <= n_u_full[SPD_W-1:0];
            r_s     <= n_s;
            r_zero4 <= (r_u == '0);
            r_pos4  <= !r_u[SPD_W-1] && (r_u != '0);
            r_hi    <= r_s[SPD_W-1:32] * i_cfg.pwm_per_speed;
            r_lo    <= r_s[31:0] * i_cfg.pwm_per_speed;
            r_zero5 <= r_zero4;
            r_pos5  <= r_pos4;
            r_duty  <= n_duty;
            r_pos6  <= r_pos5;
        end
    end

    assign o_res.duty = r_duty;
    assign o_res.pos  = r_pos6;

endmodule

`default_nettype wire

// ===== design/omni_wheel_drive_mixer.sv =====
// Top level of the omni wheel drive mixer: body terms, valid chain and configuration registers.
//
//   channel   direction   handshake                    word
//   in        input       i_in_valid / o_in_ready      t_in  (vel_x, vel_y, yaw_rate)
//   out       output      o_out_valid / i_out_ready    t_out (three duties, three dirs)
//   cfg       input       i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// An accepted word passes through the six register stages below, and o_out_valid rises as it
// reaches the last one; one word is taken per cycle while the output is not stalled.
// The six register stages are two body-term stages here and four in each wheel lane.
// A stall on the output freezes every stage together; nothing is dropped or repeated.
// Reset clears the valid chain and loads the register defaults; there is no clearing pass.
// The configuration port is always ready.
`default_nettype none

module omni_wheel_drive_mixer (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  wire owdm_pkg::t_in i_in_data,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output owdm_pkg::t_out     o_out_data,
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire [2:0]          i_cfg_index,
    input  wire [23:0]         i_cfg_data
);
    import owdm_pkg::*;

    logic [15:0] r_arm_length;
    logic [15:0] r_inv_radius;
    logic [15:0] r_spd_offset;
    logic [23:0] r_pwm_per_speed;
    logic [15:0] r_pwm_full;

    logic [5:0]  r_vld;
    logic        n_en;

    logic signed [32:0]       r_rot;
    logic signed [32:0]       r_fwd;
    logic signed [15:0]       r_vy;
    logic signed [TERM_W-1:0] n_half;
    logic signed [TERM_W-1:0] n_full;
    logic signed [TERM_W-1:0] r_t1;
    logic signed [TERM_W-1:0] r_t2;
    logic signed [TERM_W-1:0] r_t3;

    t_lane_cfg w_cfg;
    t_wheel    w_res1;
    t_wheel    w_res2;
    t_wheel    w_res3;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arm_length    <= RST_ARM_LENGTH;
            r_inv_radius    <= RST_INV_RADIUS;
            r_spd_offset    <= RST_SPD_OFFSET;
            r_pwm_per_speed <= RST_PWM_PER_SPEED;
            r_pwm_full      <= RST_PWM_FULL;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ARM_LENGTH:    r_arm_length    <= i_cfg_data[15:0];
                CFG_INV_RADIUS:    r_inv_radius    <= i_cfg_data[15:0];
                CFG_SPD_OFFSET:    r_spd_offset    <= i_cfg_data[15:0];
                CFG_PWM_PER_SPEED: r_pwm_per_speed <= i_cfg_data;
                CFG_PWM_FULL:      r_pwm_full      <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // The whole pipe moves when the output register is empty or being drained.
    assign n_en        = !r_vld[5] || i_out_ready;
    assign o_in_ready  = n_en;
    assign o_out_valid = r_vld[5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (n_en) begin
            r_vld <= {r_vld[4:0], i_in_valid};
        end
    end

    // vy/2 and vy aligned to Q.24.
    assign n_half = {{3{r_vy[15]}}, r_vy, 15'b0};
    assign n_full = {{2{r_vy[15]}}, r_vy, 16'b0};

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_rot <= $signed({1'b0, r_arm_length}) * i_in_data.yaw_rate;
            r_fwd <= i_in_data.vel_x * SIN60_Q16;
            r_vy  <= i_in_data.vel_y;
            r_t1  <= {r_rot[32], r_rot} - n_half + {r_fwd[32], r_fwd};
            r_t2  <= {r_rot[32], r_rot} - n_half - {r_fwd[32], r_fwd};
            r_t3  <= {r_rot[32], r_rot} + n_full;
        end
    end

    assign w_cfg.inv_radius    = r_inv_radius;
    assign w_cfg.spd_offset    = r_spd_offset;
    assign w_cfg.pwm_per_speed = r_pwm_per_speed;
    assign w_cfg.pwm_full      = r_pwm_full;

    owdm_wheel u_wheel1 (
        .i_clk  (i_clk),
        .i_en   (n_en),
        .i_term (r_t1),
        .i_cfg  (w_cfg),
        .o_res  (w_res1)
    );

    owdm_wheel u_wheel2 (
        .i_clk  (i_clk),
        .i_en   (n_en),
        .i_term (r_t2),
        .i_cfg  (w_cfg),
        .o_res  (w_res2)
    );

    owdm_wheel u_wheel3 (
        .i_clk  (i_clk),
        .i_en   (n_en),
        .i_term (r_t3),
        .i_cfg  (w_cfg),
        .o_res  (w_res3)
    );

    // Wheel two is mounted the other way round, so its direction sense is inverted.
    assign o_out_data.duty_one   = w_res1.duty;
    assign o_out_data.duty_two   = w_res2.duty;
    assign o_out_data.duty_three = w_res3.duty;
    assign o_out_data.dir_one    = !w_res1.pos;
    assign o_out_data.dir_two    = w_res2.pos;
    assign o_out_data.dir_three  = !w_res3.pos;

endmodule

`default_nettype wire

// ===== design/owdm_checker.sv =====
// Port checker for the omni wheel drive mixer and its bind to the top level.
`default_nettype none

module owdm_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 o_in_ready,
    input wire                 o_out_valid,
    input wire                 i_out_ready,
    input wire owdm_pkg::t_out o_out_data,
    input wire                 o_cfg_ready
);

    // A word held on the output does not change until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("output word changed while stalled");

    // Input side is never blocked while the output side is free.
    a_in_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || i_out_ready) |-> o_in_ready)
        else $error("input stalled with free output");

    // The output register is empty right after reset.
    a_rst_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("output valid after reset");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind omni_wheel_drive_mixer owdm_checker u_owdm_checker (.*);

`default_nettype wire

// ===== dv/owdm_drive_checker.sv =====
// Checker for the omni wheel drive mixer: predicts every wheel word and compares it field by field.
module owdm_drive_checker (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    input  wire            i_in_ready,
    input  owdm_pkg::t_in  i_in_data,
    input  wire            i_out_valid,
    input  wire            i_out_ready,
    input  owdm_pkg::t_out i_out_data,
    input  wire            i_cfg_valid,
    input  wire            i_cfg_ready,
    input  wire  [2:0]     i_cfg_index,
    input  wire  [23:0]    i_cfg_data,
    output int             o_errors,
    output int             o_pending,
    output int             o_words
);
    timeunit 1ns;
    timeprecision 1ps;
    import owdm_pkg::*;

    localparam longint SIN_SIXTY = 56755;

    localparam logic [15:0] ARM_DEFAULT  = 16'd23593;
    localparam logic [15:0] IR_DEFAULT   = 16'd2560;
    localparam logic [15:0] MIN_DEFAULT  = 16'd256;
    localparam logic [23:0] PPS_DEFAULT  = 24'd536981;
    localparam logic [15:0] FULL_DEFAULT = 16'd65025;

    logic [15:0] arm_q;
    logic [15:0] ir_q;
    logic [15:0] min_q;
    logic [23:0] pps_q;
    logic [15:0] full_q;

    t_out drive_fifo[$];
    int   errs  = 0;
    int   words = 0;

    // Wheel speed is Q.32 and pwm_per_speed Q.8, so the integer duty sits 40 bits up.
    function automatic logic [15:0] wheel_duty(longint spd);
        logic [79:0] mag;
        logic [79:0] scaled;
        if (spd == 0) return 16'd0;
        mag = (spd < 0) ? -spd : spd;
        scaled = (mag + ({64'd0, min_q} << 24)) * {56'd0, pps_q};
        scaled = scaled >> 40;
        if (scaled > {64'd0, full_q}) return full_q;
        return scaled[15:0];
    endfunction

    function automatic t_out mix_command(t_in cmd);
        longint rot;
        longint fwd;
        longint half_y;
        longint full_y;
        longint ir;
        longint spd_one;
        longint spd_two;
        longint spd_three;
        t_out   res;
        rot    = $signed({48'd0, arm_q}) * longint'($signed(cmd.yaw_rate));
        fwd    = longint'($signed(cmd.vel_x)) * SIN_SIXTY;
        half_y = longint'($signed(cmd.vel_y)) * 32768;
        full_y = longint'($signed(cmd.vel_y)) * 65536;
        ir     = $signed({48'd0, ir_q});
        spd_one   = (rot - half_y + fwd) * ir;
        spd_two   = (rot - half_y - fwd) * ir;
        spd_three = (rot + full_y) * ir;
        res.duty_one   = wheel_duty(spd_one);
        res.duty_two   = wheel_duty(spd_two);
        res.duty_three = wheel_duty(spd_three);
        // Wheel two is mounted the other way round, so its sense is inverted.
        res.dir_one    = !(spd_one > 0);
        res.dir_two    = (spd_two > 0);
        res.dir_three  = !(spd_three > 0);
        return res;
    endfunction

    function automatic int field_diff(string name, logic [15:0] want_v, logic [15:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            arm_q  = ARM_DEFAULT;
            ir_q   = IR_DEFAULT;
            min_q  = MIN_DEFAULT;
            pps_q  = PPS_DEFAULT;
            full_q = FULL_DEFAULT;
            drive_fifo.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ARM_LENGTH:    arm_q  = i_cfg_data[15:0];
                    CFG_INV_RADIUS:    ir_q   = i_cfg_data[15:0];
                    CFG_SPD_OFFSET:    min_q  = i_cfg_data[15:0];
                    CFG_PWM_PER_SPEED: pps_q  = i_cfg_data;
                    CFG_PWM_FULL:      full_q = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            // The output is checked before the new command is queued, since a word
            // leaving at this edge cannot belong to a command taken at the same edge.
            if (i_out_valid && i_out_ready) begin
                words++;
                if (drive_fifo.size() == 0) begin
                    errs++;
                    $display("%0t: wheel word with no command pending, expected none, got %h",
                             $time, i_out_data);
                end else begin
                    want = drive_fifo.pop_front();
                    errs += field_diff("duty_one", want.duty_one, i_out_data.duty_one);
                    errs += field_diff("duty_two", want.duty_two, i_out_data.duty_two);
                    errs += field_diff("duty_three", want.duty_three, i_out_data.duty_three);
                    errs += field_diff("dir_one", 16'(want.dir_one), 16'(i_out_data.dir_one));
                    errs += field_diff("dir_two", 16'(want.dir_two), 16'(i_out_data.dir_two));
                    errs += field_diff("dir_three", 16'(want.dir_three),
                                       16'(i_out_data.dir_three));
                end
            end
            if (i_in_valid && i_in_ready) drive_fifo.push_back(mix_command(i_in_data));
        end
        o_errors  <= errs;
        o_pending <= drive_fifo.size();
        o_words   <= words;
    end

endmodule

// ===== dv/omni_wheel_drive_mixer_tb.sv =====
// Testbench top for the omni wheel drive mixer: clock, reset, command and register stimulus, verdict.
module omni_wheel_drive_mixer_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import owdm_pkg::*;

    // Indexes past the last register; writes to them must change nothing.
    localparam logic [2:0] CFG_SPARE_FIRST = 3'd5;

    localparam int PHASES     = 8;
    localparam int PHASE_CMDS = 75;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out        o_out_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [23:0] i_cfg_data;

    int errors;
    int pending;
    int words;

    int n_cmds      = 0;
    int n_settings  = 1;
    int hold_reqs   = 0;
    bit idle_on     = 1'b0;

    always #1 i_clk = ~i_clk;

    omni_wheel_drive_mixer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    owdm_drive_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_words     (words)
    );

    function automatic logic signed [15:0] rand_field();
        case ($urandom_range(0, 9))
            0:       return 16'sd0;
            1:       return 16'sh7FFF;
            2:       return 16'sh8000;
            3, 4, 5: return 16'($urandom_range(0, 1023) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_cmd(input logic signed [15:0] vx, input logic signed [15:0] vy,
                            input logic signed [15:0] wz);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_data  = '{vel_x: vx, vel_y: vy, yaw_rate: wz};
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        n_cmds++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Stop offering commands and let every queued wheel word come out.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Output side: random stalls before words while idle_on is set, plus a long hold-off when asked.
    initial begin
        int stall;
        int hold_done;
        int hold_len;
        i_out_ready = 1'b0;
        hold_done   = 0;
        forever begin
            @(negedge i_clk);
            if (hold_reqs != hold_done) begin
                hold_done   = hold_reqs;
                hold_len    = $urandom_range(40, 64);
                i_out_ready = 1'b0;
                repeat (hold_len) @(negedge i_clk);
            end
            stall = idle_on ? $urandom_range(0, 3) : 0;
            if (stall > 0) begin
                i_out_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    initial begin
        #400000;
        $display("Timeout with %0d wheel words still outstanding.", pending);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_ARM_LENGTH;
        i_cfg_data  = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed commands on the reset settings: field extremes, single axes, signs.
        send_cmd(16'sd0, 16'sd0, 16'sd0);
        send_cmd(16'sh7FFF, 16'sd0, 16'sd0);
        send_cmd(16'sh8000, 16'sd0, 16'sd0);
        send_cmd(16'sd0, 16'sh7FFF, 16'sd0);
        send_cmd(16'sd0, 16'sh8000, 16'sd0);
        send_cmd(16'sd0, 16'sd0, 16'sh7FFF);
        send_cmd(16'sd0, 16'sd0, 16'sh8000);
        send_cmd(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_cmd(16'sh8000, 16'sh8000, 16'sh8000);
        send_cmd(16'sd256, 16'sd0, 16'sd0);
        send_cmd(-16'sd256, 16'sd0, 16'sd0);
        send_cmd(16'sd0, 16'sd256, 16'sd0);
        send_cmd(16'sd0, -16'sd256, 16'sd0);
        send_cmd(16'sd0, 16'sd0, 16'sd256);
        send_cmd(16'sd0, 16'sd0, -16'sd256);
        send_cmd(16'sd1, 16'sd0, 16'sd0);
        send_cmd(16'sd0, 16'sd0, -16'sd1);
        send_cmd(16'sd100, -16'sd200, 16'sd300);
        drain();

        // With the arm at one half, equal yaw and sideways inputs stop wheels one and two.
        write_reg(CFG_ARM_LENGTH, 24'd32768);
        n_settings++;
        send_cmd(16'sd0, 16'sd300, 16'sd300);
        send_cmd(16'sd0, -16'sd300, -16'sd300);
        send_cmd(16'sd0, 16'sd1, 16'sd1);
        drain();

        // A zero reciprocal radius stops every wheel whatever the command.
        write_reg(CFG_INV_RADIUS, 24'd0);
        n_settings++;
        send_cmd(16'sd1000, -16'sd1000, 16'sd1000);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    write_reg(CFG_ARM_LENGTH, 24'(RST_ARM_LENGTH));
                    write_reg(CFG_INV_RADIUS, 24'(RST_INV_RADIUS));
                    write_reg(CFG_SPD_OFFSET, 24'(RST_SPD_OFFSET));
                    write_reg(CFG_PWM_PER_SPEED, RST_PWM_PER_SPEED);
                    write_reg(CFG_PWM_FULL, 24'(RST_PWM_FULL));
                end
                1: begin
                    write_reg(CFG_ARM_LENGTH, 24'd0);
                    write_reg(CFG_INV_RADIUS, 24'd0);
                    write_reg(CFG_SPD_OFFSET, 24'd0);
                    write_reg(CFG_PWM_PER_SPEED, 24'd0);
                    write_reg(CFG_PWM_FULL, 24'd0);
                end
                2: begin
                    // Upper data bits must be dropped by the 16 bit registers.
                    write_reg(CFG_ARM_LENGTH, 24'hFFFFFF);
                    write_reg(CFG_INV_RADIUS, 24'hFFFFFF);
                    write_reg(CFG_SPD_OFFSET, 24'hFFFFFF);
                    write_reg(CFG_PWM_PER_SPEED, 24'hFFFFFF);
                    write_reg(CFG_PWM_FULL, 24'hFFFFFF);
                end
                3: begin
                    write_reg(CFG_ARM_LENGTH, 24'($urandom));
                    write_reg(CFG_INV_RADIUS, 24'($urandom_range(0, 4095)));
                    write_reg(CFG_SPD_OFFSET, 24'($urandom_range(0, 1023)));
                    write_reg(CFG_PWM_PER_SPEED, 24'($urandom_range(0, 65535)));
                    write_reg(CFG_PWM_FULL, 24'($urandom));
                end
                default: begin
                    write_reg(CFG_ARM_LENGTH, 24'($urandom));
                    write_reg(CFG_INV_RADIUS, 24'($urandom));
                    write_reg(CFG_SPD_OFFSET, 24'($urandom));
                    write_reg(CFG_PWM_PER_SPEED, 24'($urandom));
                    write_reg(CFG_PWM_FULL, 24'($urandom));
                end
            endcase
            write_reg(CFG_SPARE_FIRST + 3'($urandom_range(0, 2)), 24'($urandom));
            n_settings++;
            idle_on = (p % 3 != 2);
            for (int k = 0; k < PHASE_CMDS; k++) begin
                // Hold the output long enough for the pipeline to fill and push back.
                if ((p == 1 || p == 5) && k == 20) hold_reqs++;
                send_cmd(rand_field(), rand_field(), rand_field());
            end
            drain();
        end

        $display("Sent %0d velocity commands and checked %0d wheel words across %0d settings,",
                 n_cmds, words, n_settings);
        $display("including zero, full-scale and random scaling with output back-pressure.");
        if (errors == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
